// File: design/pdc_pkg.sv
package pdc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Fixed result widths
  localparam int unsigned DRIFT_W   = 33;
  localparam int unsigned CHORD_W   = 17;
  localparam int unsigned FRAC_BITS = 8;

  // Widest point count over the parameter range (up to 4096 points)
  localparam int unsigned CNT_W_MAX = 13;

  // One finished path handed from the loader to the engine
  typedef struct packed {
    logic [CNT_W_MAX-1:0] count;
    logic                 dropped;
  } job_t;

  // Engine sequencer
  typedef enum logic [4:0] {
    BK_IDLE,
    BK_RD_A,
    BK_RD_B,
    BK_EDGE,
    BK_LEN,
    BK_CHORD_GO,
    BK_CHORD_WAIT,
    BK_PT_RD,
    BK_PT_DIFF,
    BK_PT_MUL,
    BK_PT_DOT,
    BK_PT_CLASS,
    BK_END_SQ,
    BK_END_GO,
    BK_MUL,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_PERP_GO,
    BK_DIST_WAIT,
    BK_DONE
  } back_state_e;

endpackage

// File: design/pdc_ram.sv
module pdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/pdc_front.sv
module pdc_front #(
  parameter int unsigned MAX_POINTS = pdc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COORD_BITS-1:0]         x_i,
  input  logic [COORD_BITS-1:0]         y_i,
  input  logic                          last_i,
  input  logic                          back_busy_i,
  input  logic                          job_pop_i,
  output logic                          busy_o,
  output logic                          job_valid_o,
  output pdc_pkg::job_t                 job_o,
  output logic                          we_o,
  output logic [$clog2(MAX_POINTS)-1:0] waddr_o,
  output logic [2*COORD_BITS-1:0]       wdata_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic          job_valid_q, job_valid_d;
  pdc_pkg::job_t job_q, job_d;
  logic          accept, room;
  logic [CW-1:0] cnt_next;
  logic          drop_next;

  assign busy_o = job_valid_q || back_busy_i;
  assign accept = start_i && !busy_o;
  assign room   = cnt_q < CW'(MAX_POINTS);

  // Store the point while there is room, else flag the drop
  assign we_o      = accept && room;
  assign waddr_o   = cnt_q[AW-1:0];
  assign wdata_o   = {x_i, y_i};
  assign cnt_next  = room ? cnt_q + CW'(1) : cnt_q;
  assign drop_next = drop_q || !room;

  // Close the path on the last word and queue it for the engine
  always_comb begin
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    job_valid_d = job_valid_q && !job_pop_i;
    job_d       = job_q;
    if (accept) begin
      if (last_i) begin
        cnt_d         = '0;
        drop_d        = 1'b0;
        job_valid_d   = 1'b1;
        job_d.count   = pdc_pkg::CNT_W_MAX'(cnt_next);
        job_d.dropped = drop_next;
      end else begin
        cnt_d  = cnt_next;
        drop_d = drop_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// File: design/pdc_isqrt.sv
module pdc_isqrt #(
  parameter int unsigned W = 50
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   op_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);

  logic [W-1:0] op_q, res_q, one_q;
  logic         run_q, done_q;
  logic [W:0]   trial;
  logic         take;

  // One root bit per cycle, digit by digit
  assign trial = {1'b0, res_q} + {1'b0, one_q};
  assign take  = {1'b0, op_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && (one_q >> 2) == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      res_q <= '0;
      one_q <= {2'b01, {(W-2){1'b0}}};
    end else if (run_q) begin
      if (take) begin
        op_q  <= op_q - trial[W-1:0];
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[W/2-1:0];

endmodule

// File: design/pdc_div.sv
module pdc_div #(
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned KW = $clog2(QW);

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] lo_q;
  logic [KW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   trial;
  logic          take;

  // Shift in one numerator bit per cycle; the freed bits collect the quotient
  assign trial = {rem_q, lo_q[QW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + KW'(1);
        if (cnt_q == KW'(QW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DW+QW-1:QW];
      lo_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      lo_q  <= {lo_q[QW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = lo_q;

endmodule

// File: design/pdc_back.sv
module pdc_back #(
  parameter int unsigned MAX_POINTS = pdc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  pdc_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          busy_o,
  output logic [$clog2(MAX_POINTS)-1:0] raddr_o,
  input  logic [2*COORD_BITS-1:0]       rdata_i,
  output logic                          valid_o,
  output logic [pdc_pkg::DRIFT_W-1:0]   drift_o,
  output logic [pdc_pkg::CHORD_W-1:0]   chord_length_o,
  output logic                          overflowed_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned D  = C + 1;
  localparam int unsigned PW = 2 * D;
  localparam int unsigned FS = 2 * pdc_pkg::FRAC_BITS;
  localparam int unsigned SW = PW + FS;
  localparam int unsigned RW = SW / 2;
  localparam int unsigned MW = 2 * PW;
  localparam int unsigned KW = $clog2(PW);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned TW = pdc_pkg::DRIFT_W;

  pdc_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]        n_q, i_q;
  logic                 ovf_q;
  logic [TW-1:0]        drift_q;
  logic [pdc_pkg::CHORD_W-1:0] chord_q;
  logic signed [C-1:0]  ax_q, ay_q, bx_q, by_q;
  logic signed [D-1:0]  ex_q, ey_q, dx_q, dy_q, fx_q, fy_q, sx_q, sy_q;
  logic [PW-1:0]        len2_q, sq_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW:0]   dot_q;
  logic [MW-1:0]        acc_q, mc_q;
  logic [PW-1:0]        mp_q;
  logic [KW-1:0]        mcnt_q;

  logic signed [C-1:0]  rd_x, rd_y;
  logic signed [PW:0]   cr_s, len2_s;
  logic                 to_start, to_end, last_pt, take_job;

  logic                 sq_start, sq_done;
  logic [SW-1:0]        sq_op;
  logic [RW-1:0]        sq_root;
  logic                 dv_start, dv_done;
  logic [SW-1:0]        dv_quo;
  logic [TW:0]          drift_sum;

  assign rd_x = rdata_i[2*C-1:C];
  assign rd_y = rdata_i[C-1:0];

  // Classify the current point against the chord
  assign cr_s     = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign len2_s   = {1'b0, len2_q};
  assign to_start = (len2_q == '0) || (dot_q <= 0);
  assign to_end   = dot_q >= len2_s;
  assign last_pt  = (i_q == n_q - CW'(1));
  assign take_job = (state_q == pdc_pkg::BK_IDLE) && job_valid_i;

  assign drift_sum = {1'b0, drift_q} + (TW+1)'(sq_root);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdc_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.count < pdc_pkg::CNT_W_MAX'(2)) begin
            state_d = pdc_pkg::BK_DONE;
          end else begin
            state_d = pdc_pkg::BK_RD_A;
          end
        end
      end
      pdc_pkg::BK_RD_A:       state_d = pdc_pkg::BK_RD_B;
      pdc_pkg::BK_RD_B:       state_d = pdc_pkg::BK_EDGE;
      pdc_pkg::BK_EDGE:       state_d = pdc_pkg::BK_LEN;
      pdc_pkg::BK_LEN:        state_d = pdc_pkg::BK_CHORD_GO;
      pdc_pkg::BK_CHORD_GO:   state_d = pdc_pkg::BK_CHORD_WAIT;
      pdc_pkg::BK_CHORD_WAIT: begin
        if (sq_done) begin
          state_d = pdc_pkg::BK_PT_RD;
        end
      end
      pdc_pkg::BK_PT_RD:      state_d = pdc_pkg::BK_PT_DIFF;
      pdc_pkg::BK_PT_DIFF:    state_d = pdc_pkg::BK_PT_MUL;
      pdc_pkg::BK_PT_MUL:     state_d = pdc_pkg::BK_PT_DOT;
      pdc_pkg::BK_PT_DOT:     state_d = pdc_pkg::BK_PT_CLASS;
      pdc_pkg::BK_PT_CLASS: begin
        if (to_start || to_end) begin
          state_d = pdc_pkg::BK_END_SQ;
        end else begin
          state_d = pdc_pkg::BK_MUL;
        end
      end
      pdc_pkg::BK_END_SQ:     state_d = pdc_pkg::BK_END_GO;
      pdc_pkg::BK_END_GO:     state_d = pdc_pkg::BK_DIST_WAIT;
      pdc_pkg::BK_MUL: begin
        if (mcnt_q == KW'(PW - 1)) begin
          state_d = pdc_pkg::BK_DIV_GO;
        end
      end
      pdc_pkg::BK_DIV_GO:     state_d = pdc_pkg::BK_DIV_WAIT;
      pdc_pkg::BK_DIV_WAIT: begin
        if (dv_done) begin
          state_d = pdc_pkg::BK_PERP_GO;
        end
      end
      pdc_pkg::BK_PERP_GO:    state_d = pdc_pkg::BK_DIST_WAIT;
      pdc_pkg::BK_DIST_WAIT: begin
        if (sq_done) begin
          state_d = last_pt ? pdc_pkg::BK_DONE : pdc_pkg::BK_PT_RD;
        end
      end
      pdc_pkg::BK_DONE:       state_d = pdc_pkg::BK_IDLE;
      default:                state_d = pdc_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    raddr_o  = i_q[AW-1:0];
    sq_start = 1'b0;
    sq_op    = dv_quo;
    dv_start = 1'b0;
    valid_o  = 1'b0;
    unique case (state_q)
      pdc_pkg::BK_RD_A:     raddr_o = '0;
      pdc_pkg::BK_RD_B:     raddr_o = AW'(n_q - CW'(1));
      pdc_pkg::BK_CHORD_GO: begin
        sq_start = 1'b1;
        sq_op    = SW'(len2_q);
      end
      pdc_pkg::BK_END_GO: begin
        sq_start = 1'b1;
        sq_op    = {sq_q, {FS{1'b0}}};
      end
      pdc_pkg::BK_PERP_GO:  sq_start = 1'b1;
      pdc_pkg::BK_DIV_GO:   dv_start = 1'b1;
      pdc_pkg::BK_DONE:     valid_o  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdc_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pdc_pkg::BK_IDLE: begin
        if (take_job) begin
          n_q     <= CW'(job_i.count);
          ovf_q   <= job_i.dropped;
          drift_q <= '0;
          chord_q <= '0;
          i_q     <= '0;
        end
      end
      pdc_pkg::BK_RD_B: begin
        ax_q <= rd_x;
        ay_q <= rd_y;
      end
      pdc_pkg::BK_EDGE: begin
        bx_q <= rd_x;
        by_q <= rd_y;
        ex_q <= D'(rd_x) - D'(ax_q);
        ey_q <= D'(rd_y) - D'(ay_q);
      end
      pdc_pkg::BK_LEN: begin
        len2_q <= PW'(ex_q * ex_q + ey_q * ey_q);
      end
      pdc_pkg::BK_CHORD_WAIT: begin
        if (sq_done) begin
          chord_q <= sq_root[pdc_pkg::CHORD_W-1:0];
        end
      end
      pdc_pkg::BK_PT_DIFF: begin
        dx_q <= D'(rd_x) - D'(ax_q);
        dy_q <= D'(rd_y) - D'(ay_q);
        fx_q <= D'(rd_x) - D'(bx_q);
        fy_q <= D'(rd_y) - D'(by_q);
      end
      pdc_pkg::BK_PT_MUL: begin
        p1_q <= PW'(dx_q * ex_q);
        p2_q <= PW'(dy_q * ey_q);
      end
      pdc_pkg::BK_PT_DOT: begin
        dot_q <= {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
        p1_q  <= PW'(dx_q * ey_q);
        p2_q  <= PW'(dy_q * ex_q);
      end
      pdc_pkg::BK_PT_CLASS: begin
        // Pick the nearer endpoint, or set up the cross product square
        mc_q   <= MW'(cr_s[PW] ? PW'(-cr_s) : cr_s[PW-1:0]);
        mp_q   <= cr_s[PW] ? PW'(-cr_s) : cr_s[PW-1:0];
        acc_q  <= '0;
        mcnt_q <= '0;
        if (to_start) begin
          sx_q <= dx_q;
          sy_q <= dy_q;
        end else begin
          sx_q <= fx_q;
          sy_q <= fy_q;
        end
      end
      pdc_pkg::BK_END_SQ: begin
        sq_q <= PW'(sx_q * sx_q + sy_q * sy_q);
      end
      pdc_pkg::BK_MUL: begin
        // Shift-add square of the cross product
        if (mp_q[0]) begin
          acc_q <= acc_q + mc_q;
        end
        mc_q   <= mc_q << 1;
        mp_q   <= mp_q >> 1;
        mcnt_q <= mcnt_q + KW'(1);
      end
      pdc_pkg::BK_DIST_WAIT: begin
        if (sq_done) begin
          drift_q <= drift_sum[TW] ? {TW{1'b1}} : drift_sum[TW-1:0];
          i_q     <= i_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  pdc_isqrt #(
    .W (SW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  pdc_div #(
    .DW (PW),
    .QW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   ({acc_q, {FS{1'b0}}}),
    .den_i   (len2_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign job_pop_o      = take_job;
  assign busy_o         = state_q != pdc_pkg::BK_IDLE;
  assign drift_o        = drift_q;
  assign chord_length_o = chord_q;
  assign overflowed_o   = ovf_q;

endmodule

// File: design/path_drift_from_chord_core.sv
// Path drift against the chord. Points load one word per cycle (start_i while
// busy_o is low); last_i closes the path and busy_o then stays high until the
// result strobe valid_o, which lasts one cycle and cannot be stalled, so the
// receiver must take drift_o, chord_length_o and overflowed_o on that cycle.
// After the last word the engine walks the stored points from the point RAM
// with one shared square-root unit and one restoring divider: setup reads the
// two endpoints and takes the chord root, a point nearest an endpoint needs
// the root of its endpoint distance, and a point projecting inside the chord
// needs the shift-add square of the cross product, the divide by the squared
// chord length and the root. Paths of fewer than two points return zeros.
// Points beyond MAX_POINTS are dropped and reported in overflowed_o.
module path_drift_from_chord_core #(
  parameter int unsigned MAX_POINTS = pdc_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [COORD_BITS-1:0]       x_i,
  input  logic [COORD_BITS-1:0]       y_i,
  input  logic                        last_i,
  output logic                        valid_o,
  output logic [pdc_pkg::DRIFT_W-1:0] drift_o,
  output logic [pdc_pkg::CHORD_W-1:0] chord_length_o,
  output logic                        overflowed_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic                    back_busy, job_valid, job_pop, we;
  pdc_pkg::job_t           job;
  logic [AW-1:0]           waddr, raddr;
  logic [2*COORD_BITS-1:0] wdata, rdata;

  pdc_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .last_i      (last_i),
    .back_busy_i (back_busy),
    .job_pop_i   (job_pop),
    .busy_o      (busy_o),
    .job_valid_o (job_valid),
    .job_o       (job),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  pdc_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pdc_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .busy_o         (back_busy),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .valid_o        (valid_o),
    .drift_o        (drift_o),
    .chord_length_o (chord_length_o),
    .overflowed_o   (overflowed_o)
  );

endmodule
